// ===== rtl/mmv_pkg.sv =====
// ----------------------------------------------------------------------------
// mmv_pkg
// Shared types and constants for the multichannel mean and variance core.
// ----------------------------------------------------------------------------
`default_nettype none

package mmv_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DATA_W    = 12;
    localparam int CHAN_W    = 2;
    localparam int OUT_CNT_W = 16;
    localparam int Q_W       = DATA_W + 1;
    localparam int DIV_STEPS = Q_W;

    localparam logic [DATA_W-1:0] VALUE_MAX = 12'hFFF;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FINAL  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NSQ,
        ST_SSQ,
        ST_NN,
        ST_VADJ,
        ST_VDIV,
        ST_MADJ,
        ST_MDIV,
        ST_OUT
    } state_t;

    // quotient bit above the 12-bit range means the value saturates
    function automatic logic [DATA_W-1:0] sat_q(input logic [Q_W-1:0] q);
        return q[Q_W-1] ? VALUE_MAX : q[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multichannel_mean_variance_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_mean_variance_core
// Per-channel running count, sum and sum of squares with a report of the
// rounded mean and population variance of every channel.
// ----------------------------------------------------------------------------
// Input beats carry op and sample on a valid/ready channel. A sample beat
// (op 0) sends its low 12 bits to the channel under the round-robin
// pointer, which then advances. A clear beat (op 2) zeroes all
// accumulators, overflow flags and the pointer. Op 3 is ignored.
// A finalize beat (op 1) walks the channels in order and sends one result
// beat per channel, last set on the final one; in_ready stays low until the
// final row is taken. Each row runs on one shared add/subtract unit:
// n*sumsq, sum^2 and n^2 by shift-add, two 13-step restoring divisions
// and the load and rounding setup states; an empty channel goes from load
// straight to the output. A stalled row simply holds on the outputs.
// Reset clears all accumulators and the pointer; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_mean_variance_core #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [mmv_pkg::SAMPLE_W-1:0]    sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mmv_pkg::CHAN_W-1:0]           channel,
    output logic [mmv_pkg::OUT_CNT_W-1:0]        sample_count,
    output logic [mmv_pkg::DATA_W-1:0]           mean,
    output logic [mmv_pkg::DATA_W-1:0]           variance,
    output logic                                 overflowed,
    output logic                                 last
);

    localparam int PW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W  = COUNT_BITS + mmv_pkg::DATA_W;
    localparam int SSQ_W  = COUNT_BITS + 2 * mmv_pkg::DATA_W;
    localparam int DW     = 2 * COUNT_BITS + 2 * mmv_pkg::DATA_W + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int SQ_W   = 2 * mmv_pkg::DATA_W;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [PW-1:0]         LAST_CH  = PW'(CHANNELS - 1);

    // accumulators
    logic [COUNT_BITS-1:0] cnt_reg [CHANNELS];
    logic [SUM_W-1:0]      sum_reg [CHANNELS];
    logic [SSQ_W-1:0]      ssq_reg [CHANNELS];
    logic                  ovf_reg [CHANNELS];
    logic [PW-1:0]         ptr_reg;

    // sequencer
    mmv_pkg::state_t       state_reg, state_next;
    logic [PW-1:0]         idx_reg, idx_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // shared unit and per-row operands
    logic [DW-1:0]         acc_reg, acc_next;
    logic [DW-1:0]         mcand_reg, mcand_next;
    logic [SUM_W-1:0]      mplier_reg, mplier_next;
    logic [mmv_pkg::Q_W-1:0] q_reg, q_next;
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [SUM_W-1:0]      s_reg, s_next;
    logic                  ovf_row_reg, ovf_row_next;
    logic [DW-1:0]         num_reg, num_next;
    logic [DW-1:0]         den_reg, den_next;
    logic [mmv_pkg::DATA_W-1:0] mean_reg, mean_next;
    logic [mmv_pkg::DATA_W-1:0] var_reg, var_next;

    logic [PW-1:0]         rd_idx;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SUM_W-1:0]      rd_sum;
    logic [SSQ_W-1:0]      rd_ssq;
    logic                  rd_ovf;

    logic                  alu_sub;
    logic [DW:0]           alu_res;
    logic [DW-1:0]         acc_step;
    logic                  no_borrow;
    logic [mmv_pkg::Q_W-1:0] q_step;

    logic                  in_beat;
    logic [mmv_pkg::DATA_W-1:0] smp;
    logic [SQ_W-1:0]       smp_sq;

    assign in_ready = (state_reg == mmv_pkg::ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign smp      = sample[mmv_pkg::DATA_W-1:0];
    assign smp_sq   = SQ_W'(smp) * SQ_W'(smp);

    // one read port, shared by sample updates and the report walk
    assign rd_idx = (state_reg == mmv_pkg::ST_IDLE) ? ptr_reg : idx_reg;
    assign rd_cnt = cnt_reg[rd_idx];
    assign rd_sum = sum_reg[rd_idx];
    assign rd_ssq = ssq_reg[rd_idx];
    assign rd_ovf = ovf_reg[rd_idx];

    assign alu_sub = (state_reg == mmv_pkg::ST_SSQ) || (state_reg == mmv_pkg::ST_VDIV)
                  || (state_reg == mmv_pkg::ST_MDIV);
    assign alu_res = alu_sub ? ({1'b0, acc_reg} - {1'b0, mcand_reg})
                             : ({1'b0, acc_reg} + {1'b0, mcand_reg});
    assign acc_step  = mplier_reg[0] ? alu_res[DW-1:0] : acc_reg;
    assign no_borrow = ~alu_res[DW];
    assign q_step    = {q_reg[mmv_pkg::Q_W-2:0], no_borrow};

    assign out_valid    = (state_reg == mmv_pkg::ST_OUT);
    assign channel      = mmv_pkg::CHAN_W'(idx_reg);
    assign sample_count = mmv_pkg::OUT_CNT_W'(n_reg);
    assign mean         = mean_reg;
    assign variance     = var_reg;
    assign overflowed   = ovf_row_reg;
    assign last         = (idx_reg == LAST_CH);

    // accumulator update on sample and clear beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c] <= '0;
                sum_reg[c] <= '0;
                ssq_reg[c] <= '0;
                ovf_reg[c] <= 1'b0;
            end
            ptr_reg <= '0;
        end
        else if (in_beat && op == mmv_pkg::OP_SAMPLE)
        begin
            if (rd_cnt == CNT_MAX)
            begin
                ovf_reg[ptr_reg] <= 1'b1;
            end
            else
            begin
                cnt_reg[ptr_reg] <= rd_cnt + COUNT_BITS'(1);
                sum_reg[ptr_reg] <= rd_sum + SUM_W'(smp);
                ssq_reg[ptr_reg] <= rd_ssq + SSQ_W'(smp_sq);
            end
            ptr_reg <= (ptr_reg == LAST_CH) ? '0 : ptr_reg + PW'(1);
        end
        else if (in_beat && op == mmv_pkg::OP_CLEAR)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c] <= '0;
                sum_reg[c] <= '0;
                ssq_reg[c] <= '0;
                ovf_reg[c] <= 1'b0;
            end
            ptr_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmv_pkg::ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        q_reg       <= q_next;
        n_reg       <= n_next;
        s_reg       <= s_next;
        ovf_row_reg <= ovf_row_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        mean_reg    <= mean_next;
        var_reg     <= var_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        q_next       = q_reg;
        n_next       = n_reg;
        s_next       = s_reg;
        ovf_row_next = ovf_row_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mean_next    = mean_reg;
        var_next     = var_reg;

        unique case (state_reg)
            mmv_pkg::ST_IDLE:
            begin
                if (in_beat && op == mmv_pkg::OP_FINAL)
                begin
                    idx_next   = '0;
                    state_next = mmv_pkg::ST_LOAD;
                end
            end
            mmv_pkg::ST_LOAD:
            begin
                n_next       = rd_cnt;
                s_next       = rd_sum;
                ovf_row_next = rd_ovf;
                acc_next     = '0;
                mcand_next   = DW'(rd_ssq);
                mplier_next  = SUM_W'(rd_cnt);
                step_next    = '0;
                if (rd_cnt == '0)
                begin
                    mean_next  = '0;
                    var_next   = '0;
                    state_next = mmv_pkg::ST_OUT;
                end
                else
                begin
                    state_next = mmv_pkg::ST_NSQ;
                end
            end
            mmv_pkg::ST_NSQ:
            begin
                // n * sumsq, one multiplier bit per cycle
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(COUNT_BITS - 1))
                begin
                    mcand_next  = DW'(s_reg);
                    mplier_next = s_reg;
                    step_next   = '0;
                    state_next  = mmv_pkg::ST_SSQ;
                end
            end
            mmv_pkg::ST_SSQ:
            begin
                // subtract sum * sum from the running product
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    num_next    = acc_step;
                    acc_next    = '0;
                    mcand_next  = DW'(n_reg);
                    mplier_next = SUM_W'(n_reg);
                    step_next   = '0;
                    state_next  = mmv_pkg::ST_NN;
                end
            end
            mmv_pkg::ST_NN:
            begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(COUNT_BITS - 1))
                begin
                    den_next   = acc_step;
                    acc_next   = num_reg;
                    mcand_next = acc_step >> 1;
                    step_next  = '0;
                    state_next = mmv_pkg::ST_VADJ;
                end
            end
            mmv_pkg::ST_VADJ:
            begin
                // rounding term added, divisor aligned to the top quotient bit
                acc_next   = alu_res[DW-1:0];
                mcand_next = den_reg << mmv_pkg::DATA_W;
                q_next     = '0;
                step_next  = '0;
                state_next = mmv_pkg::ST_VDIV;
            end
            mmv_pkg::ST_VDIV:
            begin
                if (no_borrow)
                begin
                    acc_next = alu_res[DW-1:0];
                end
                q_next     = q_step;
                mcand_next = mcand_reg >> 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(mmv_pkg::DIV_STEPS - 1))
                begin
                    var_next   = mmv_pkg::sat_q(q_step);
                    acc_next   = DW'(s_reg);
                    mcand_next = DW'(n_reg >> 1);
                    step_next  = '0;
                    state_next = mmv_pkg::ST_MADJ;
                end
            end
            mmv_pkg::ST_MADJ:
            begin
                acc_next   = alu_res[DW-1:0];
                mcand_next = DW'(n_reg) << mmv_pkg::DATA_W;
                q_next     = '0;
                step_next  = '0;
                state_next = mmv_pkg::ST_MDIV;
            end
            mmv_pkg::ST_MDIV:
            begin
                if (no_borrow)
                begin
                    acc_next = alu_res[DW-1:0];
                end
                q_next     = q_step;
                mcand_next = mcand_reg >> 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(mmv_pkg::DIV_STEPS - 1))
                begin
                    mean_next  = mmv_pkg::sat_q(q_step);
                    step_next  = '0;
                    state_next = mmv_pkg::ST_OUT;
                end
            end
            mmv_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == LAST_CH)
                    begin
                        state_next = mmv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + PW'(1);
                        state_next = mmv_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = mmv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/tb_multichannel_mean_variance_core.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_mean_variance_core
// Self-checking bench for the multichannel mean and variance core: directed
// beats for empty channels, masking, the unused op and clear, then random
// sample bursts and reports under several idle/stall mixes. Every report row
// is compared field by field against an in-bench accumulator model.
// ----------------------------------------------------------------------------
module tb_multichannel_mean_variance_core;

    localparam int NUM_CH       = 4;
    localparam int COUNT_W      = 16;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
    localparam int HANG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = NUM_CH * (3 * COUNT_W + 43) + 20;

    typedef struct {
        logic [mmv_pkg::CHAN_W-1:0]    channel;
        logic [mmv_pkg::OUT_CNT_W-1:0] count;
        logic [mmv_pkg::DATA_W-1:0]    mean;
        logic [mmv_pkg::DATA_W-1:0]    variance;
        logic                          ovf;
        logic                          last;
    } report_row_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    mmv_pkg::op_t                  op        = mmv_pkg::OP_NONE;
    logic [mmv_pkg::SAMPLE_W-1:0]  sample    = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [mmv_pkg::CHAN_W-1:0]    channel;
    logic [mmv_pkg::OUT_CNT_W-1:0] sample_count;
    logic [mmv_pkg::DATA_W-1:0]    mean;
    logic [mmv_pkg::DATA_W-1:0]    variance;
    logic                          overflowed;
    logic                          last;

    // accumulator copy kept in step with accepted input beats
    logic [COUNT_W-1:0]         acc_count [NUM_CH];
    logic [27:0]                acc_sum   [NUM_CH];
    logic [39:0]                acc_sumsq [NUM_CH];
    logic                       acc_ovf   [NUM_CH];
    logic [mmv_pkg::CHAN_W-1:0] acc_ptr;
    report_row_t                pending_rows[$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int ready_stall_pct = 0;

    multichannel_mean_variance_core #(
        .CHANNELS   (NUM_CH),
        .COUNT_BITS (COUNT_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .channel      (channel),
        .sample_count (sample_count),
        .mean         (mean),
        .variance     (variance),
        .overflowed   (overflowed),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_accumulators();
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc_count[c] = '0;
            acc_sum[c]   = '0;
            acc_sumsq[c] = '0;
            acc_ovf[c]   = 1'b0;
        end
        acc_ptr = '0;
    endfunction

    // update the accumulators for one accepted beat, queue any report rows
    function automatic void accumulate_beat(input mmv_pkg::op_t code,
                                            input logic [mmv_pkg::SAMPLE_W-1:0] word);
        logic [mmv_pkg::DATA_W-1:0] v;
        report_row_t                row;
        longint unsigned            n, tot, num, den, mu, vr;
        v = word[mmv_pkg::DATA_W-1:0];
        case (code)
            mmv_pkg::OP_SAMPLE:
            begin
                if (acc_count[acc_ptr] == COUNT_W'(COUNT_MAX))
                    acc_ovf[acc_ptr] = 1'b1;
                else
                begin
                    acc_count[acc_ptr] = acc_count[acc_ptr] + COUNT_W'(1);
                    acc_sum[acc_ptr]   = acc_sum[acc_ptr] + 28'(v);
                    acc_sumsq[acc_ptr] = acc_sumsq[acc_ptr] + 40'(v) * 40'(v);
                end
                acc_ptr = (acc_ptr == mmv_pkg::CHAN_W'(NUM_CH - 1)) ? '0
                        : acc_ptr + mmv_pkg::CHAN_W'(1);
            end
            mmv_pkg::OP_FINAL:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    n  = 64'(acc_count[c]);
                    mu = 0;
                    vr = 0;
                    if (n != 0)
                    begin
                        tot = 64'(acc_sum[c]);
                        num = n * 64'(acc_sumsq[c]) - tot * tot;
                        den = n * n;
                        mu  = (tot + n / 2) / n;
                        vr  = (num + den / 2) / den;
                    end
                    row.channel  = mmv_pkg::CHAN_W'(c);
                    row.count    = mmv_pkg::OUT_CNT_W'(n);
                    row.mean     = (mu > 64'(mmv_pkg::VALUE_MAX)) ? mmv_pkg::VALUE_MAX
                                 : mu[mmv_pkg::DATA_W-1:0];
                    row.variance = (vr > 64'(mmv_pkg::VALUE_MAX)) ? mmv_pkg::VALUE_MAX
                                 : vr[mmv_pkg::DATA_W-1:0];
                    row.ovf      = acc_ovf[c];
                    row.last     = (c == NUM_CH - 1);
                    pending_rows.push_back(row);
                end
            end
            mmv_pkg::OP_CLEAR:
                clear_accumulators();
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // receiver backpressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);

    always @(posedge clk)
    begin
        report_row_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected report beat, actual channel %0d count %0d",
                         $time, channel, sample_count);
                errors++;
            end
            else
            begin
                want = pending_rows.pop_front();
                check_field("channel",      64'(want.channel),  64'(channel));
                check_field("sample_count", 64'(want.count),    64'(sample_count));
                check_field("mean",         64'(want.mean),     64'(mean));
                check_field("variance",     64'(want.variance), 64'(variance));
                check_field("overflowed",   64'(want.ovf),      64'(overflowed));
                check_field("last",         64'(want.last),     64'(last));
            end
        end
    end

    // hang detection: nothing moving on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
    endtask

    task automatic send_beat(input mmv_pkg::op_t code,
                             input logic [mmv_pkg::SAMPLE_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        sample   <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_beat(code, word);
    endtask

    // sample near base with a given spread, upper bits are junk the block masks off
    function automatic logic [mmv_pkg::SAMPLE_W-1:0] noisy_sample(input int base,
                                                                  input int spread);
        int         v;
        logic [3:0] junk;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        junk = 4'($urandom_range(0, 15));
        return {junk, v[11:0]};
    endfunction

    task automatic test_empty_report();
        send_beat(mmv_pkg::OP_FINAL, 16'h0000);
    endtask

    task automatic test_field_extremes();
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0000);
        send_beat(mmv_pkg::OP_SAMPLE, 16'hFFFF);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0FFF);
        send_beat(mmv_pkg::OP_SAMPLE, 16'hF000);
        send_beat(mmv_pkg::OP_SAMPLE, 16'hA5A5);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h5A5A);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0001);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h8000);
        send_beat(mmv_pkg::OP_FINAL, 16'hFFFF);
    endtask

    // op 3 must leave accumulators and the pointer alone
    task automatic test_unused_op();
        send_beat(mmv_pkg::OP_NONE, 16'hFFFF);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0123);
        send_beat(mmv_pkg::OP_NONE, 16'h0456);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0002);
        send_beat(mmv_pkg::OP_FINAL, 16'h0000);
    endtask

    task automatic test_clear();
        send_beat(mmv_pkg::OP_CLEAR, 16'h0FFF);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h000C);
        send_beat(mmv_pkg::OP_SAMPLE, 16'h0003);
        send_beat(mmv_pkg::OP_FINAL, 16'h0000);
    endtask

    // bursts of samples with a random center and spread, each closed by a report
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int roll;
        int len;
        int base;
        int spread;
        set_idling(idle_pct, stall_pct);
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                send_beat(mmv_pkg::OP_CLEAR, mmv_pkg::SAMPLE_W'($urandom));
                sent++;
            end
            else if (roll >= 95)
                send_beat(mmv_pkg::OP_NONE, mmv_pkg::SAMPLE_W'($urandom));
            else if (roll >= 90)
            begin
                send_beat(mmv_pkg::op_t'($urandom_range(0, 2)),
                          mmv_pkg::SAMPLE_W'($urandom));
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       base = 0;
                1:       base = 4095;
                default: base = $urandom_range(0, 4095);
            endcase
            case ($urandom_range(0, 4))
                0:       spread = 0;
                1:       spread = 2;
                2:       spread = 9;
                3:       spread = 40;
                default: spread = 2048;
            endcase
            len = $urandom_range(1, 32);
            repeat (len)
            begin
                send_beat(mmv_pkg::OP_SAMPLE, noisy_sample(base, spread));
                sent++;
            end
            send_beat(mmv_pkg::OP_FINAL, mmv_pkg::SAMPLE_W'($urandom));
            sent++;
        end
    endtask

    task automatic wait_drained();
        set_idling(0, 0);
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        clear_accumulators();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        set_idling(0, 0);
        test_empty_report();
        test_field_extremes();
        test_unused_op();
        test_clear();

        test_random_traffic(125, 0, 0);
        test_random_traffic(125, 82, 0);
        test_random_traffic(125, 0, 82);
        test_random_traffic(125, 35, 35);

        wait_drained();
        if (pending_rows.size() != 0)
        begin
            $display("%0t: %0d report rows never arrived", $time, pending_rows.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmv_pkg.sv
rtl/multichannel_mean_variance_core.sv
bench/tb_multichannel_mean_variance_core.sv
